FILE: hw/rtl/fsg_pkg.sv
package fsg_pkg;

  localparam int GRID_X = 128;
  localparam int GRID_Y = 128;
  localparam int KERNEL_ENTRIES = 512;

  localparam int XW = $clog2(GRID_X);
  localparam int YW = $clog2(GRID_Y);
  localparam int AW = XW + YW;
  localparam int KW = $clog2(KERNEL_ENTRIES);
  localparam int CELLS = GRID_X * GRID_Y;
  localparam int WW = 32 + $clog2(CELLS);

  localparam longint unsigned Q28_ONE = 64'd268435456;
  localparam longint unsigned PI_Q28 = 64'd843314857;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_DEPOSIT = 2'd1,
    OP_READ    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef logic [15:0] kern_tab_t [KERNEL_ENTRIES];

  function automatic kern_tab_t build_kernel();
    kern_tab_t tab;
    longint unsigned m;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned term;
    longint unsigned v;
    longint c;
    bit upper;
    for (int k = 0; k < KERNEL_ENTRIES; k++) begin
      upper = (2 * k) > KERNEL_ENTRIES;
      m = upper ? longint'(KERNEL_ENTRIES - k) : longint'(k);
      t = (PI_Q28 * m) / KERNEL_ENTRIES;
      t2 = (t * t) >> 28;
      term = Q28_ONE;
      c = longint'(Q28_ONE);
      for (int n = 1; n <= 8; n++) begin
        term = (term * t2) >> 28;
        case (n)
          1: term = term / 2;
          2: term = term / 12;
          3: term = term / 30;
          4: term = term / 56;
          5: term = term / 90;
          6: term = term / 132;
          7: term = term / 182;
          default: term = term / 240;
        endcase
        if (n % 2 == 1) begin
          c = c - longint'(term);
        end else begin
          c = c + longint'(term);
        end
      end
      if (c < 0) c = 0;
      if (c > longint'(Q28_ONE)) c = longint'(Q28_ONE);
      v = upper ? (Q28_ONE - longint'(c)) : (Q28_ONE + longint'(c));
      tab[k] = 16'((v + 64'd8192) >> 14);
    end
    return tab;
  endfunction

  localparam kern_tab_t KERNEL = build_kernel();

  // delta for cell i of the four around a node, frac is the in-cell offset
  function automatic logic [15:0] axis_delta(logic [23:0] frac, logic [1:0] i);
    logic [25:0] reach;
    logic [39:0] prod;
    logic [14:0] idx;
    case (i)
      2'd0: reach = 26'(frac) + 26'h1000000;
      2'd1: reach = 26'(frac);
      2'd2: reach = 26'h1000000 - 26'(frac);
      default: reach = 26'h2000000 - 26'(frac);
    endcase
    prod = 40'(reach) * 40'(KERNEL_ENTRIES);
    idx = prod[39:25];
    return (idx < 15'(KERNEL_ENTRIES)) ? KERNEL[idx[KW-1:0]] : 16'd0;
  endfunction

endpackage

FILE: hw/rtl/force_spreading_to_grid_core.sv
// force spreading onto two periodic 48-bit force grids (x and y components)
// input channel s_*: one transfer per operation, tuser carries the operation
//   clear zeroes both grids, deposit spreads one node force over 4x4 cells,
//   read returns one cell of both grids, code 3 is dropped
// output channel m_*: one transfer per read, both grid values in tdata
// deposit: a setup state, then 16 cell issues through a shared five-stage
//   multiply/accumulate unit (one cell read-modify-write per cycle on both
//   grids), then a drain state until the unit is empty; s_tready is low from
//   the setup state until the drain state returns to idle
// read: the result passes through the read state, the registered grid memory
//   read port and the load state before it shows on m_*
// clear: one cell of both grids per cycle over all 16384 cells
// reset: the same clearing pass runs, s_tready stays low until the pass ends
// a stalled output holds its result, s_tready stays low while a result waits
module force_spreading_to_grid_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x[23:0] pos_y[47:24] force_x[79:48] force_y[111:80]
  // node_spacing[135:112] cell_x[142:136] cell_y[149:143] zero[151:150]
  input  logic [151:0] s_tdata,
  // operation[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // grid_force_x[47:0] grid_force_y[95:48]
  output logic [95:0]  m_tdata
);
  import fsg_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SETUP, ST_RUN, ST_DRAIN, ST_READ, ST_LOAD
  } state_t;

  state_t state;
  logic [AW-1:0] clr_addr;
  logic [3:0] cnt;
  logic a_vld, b_vld, c_vld, d_vld, e_vld;

  logic [23:0] pos_x_r, pos_y_r, dl_r;
  logic [31:0] mag_x, mag_y;
  logic neg_x, neg_y;
  logic [AW-1:0] rd_addr;

  logic [15:0] dxr [4];
  logic [15:0] dyr [4];
  logic [XW-1:0] cxr [4];
  logic [YW-1:0] cyr [4];

  logic [15:0] a_dx, a_dy;
  logic [AW-1:0] a_addr, b_addr, c_addr, d_addr, e_addr;
  logic [31:0] b_p;
  logic [55:0] c_p;
  logic [63:0] d_lo_x, d_lo_y;
  logic [63:0] d_hi_x, d_hi_y;
  logic signed [63:0] e_cx, e_cy;

  logic signed [47:0] mem_x [CELLS];
  logic signed [47:0] mem_y [CELLS];
  logic signed [47:0] rd_x, rd_y;
  logic [AW-1:0] rd_sel;

  logic [24+XW:0] gx;
  logic [24+YW:0] gy;
  logic [15:0] dx_next [4];
  logic [15:0] dy_next [4];
  logic [XW-1:0] cx_next [4];
  logic [YW-1:0] cy_next [4];
  logic [XW+1:0] tx;
  logic [YW+1:0] ty;

  logic [31:0] wv;
  logic [WW-1:0] w;
  logic [63:0] res_x, res_y;
  logic signed [65:0] sum_x, sum_y;
  logic signed [47:0] sat_x, sat_y;
  logic s_xfer;
  op_t op;

  assign op = op_t'(s_tuser);
  assign s_tready = (state == ST_IDLE) && !m_tvalid;
  assign s_xfer = s_tvalid && s_tready;

  always_comb begin
    gx = (XW + 25)'(pos_x_r) * (XW + 25)'(GRID_X);
    gy = (YW + 25)'(pos_y_r) * (YW + 25)'(GRID_Y);
    for (int i = 0; i < 4; i++) begin
      dx_next[i] = axis_delta(gx[23:0], 2'(i));
      dy_next[i] = axis_delta(gy[23:0], 2'(i));
      tx = (XW + 2)'(gx[24+XW-1:24]) + (XW + 2)'(i);
      tx = (tx == '0) ? (XW + 2)'(GRID_X - 1) : tx - 1'b1;
      if (tx >= (XW + 2)'(GRID_X)) tx = tx - (XW + 2)'(GRID_X);
      cx_next[i] = tx[XW-1:0];
      ty = (YW + 2)'(gy[24+YW-1:24]) + (YW + 2)'(i);
      ty = (ty == '0) ? (YW + 2)'(GRID_Y - 1) : ty - 1'b1;
      if (ty >= (YW + 2)'(GRID_Y)) ty = ty - (YW + 2)'(GRID_Y);
      cy_next[i] = ty[YW-1:0];
    end
  end

  assign wv = c_p[55:24];
  assign w = WW'(wv) * WW'(CELLS);
  assign res_x = d_hi_x + ((d_lo_x + 64'h80000000) >> 32);
  assign res_y = d_hi_y + ((d_lo_y + 64'h80000000) >> 32);

  always_comb begin
    sum_x = 66'(rd_x) + 66'(e_cx);
    sum_y = 66'(rd_y) + 66'(e_cy);
    if (sum_x > 66'sh7FFFFFFFFFFF) sat_x = 48'sh7FFFFFFFFFFF;
    else if (sum_x < -66'sh800000000000) sat_x = 48'sh800000000000;
    else sat_x = sum_x[47:0];
    if (sum_y > 66'sh7FFFFFFFFFFF) sat_y = 48'sh7FFFFFFFFFFF;
    else if (sum_y < -66'sh800000000000) sat_y = 48'sh800000000000;
    else sat_y = sum_y[47:0];
  end

  assign rd_sel = (state == ST_READ) ? rd_addr : d_addr;

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      mem_x[clr_addr] <= '0;
      mem_y[clr_addr] <= '0;
    end else if (e_vld) begin
      mem_x[e_addr] <= sat_x;
      mem_y[e_addr] <= sat_y;
    end
    rd_x <= mem_x[rd_sel];
    rd_y <= mem_y[rd_sel];
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      pos_x_r <= s_tdata[23:0];
      pos_y_r <= s_tdata[47:24];
      neg_x   <= s_tdata[79];
      neg_y   <= s_tdata[111];
      mag_x   <= s_tdata[79] ? (32'd0 - s_tdata[79:48]) : s_tdata[79:48];
      mag_y   <= s_tdata[111] ? (32'd0 - s_tdata[111:80]) : s_tdata[111:80];
      dl_r    <= s_tdata[135:112];
      rd_addr <= {s_tdata[136 +: XW], s_tdata[143 +: YW]};
    end
    if (state == ST_SETUP) begin
      dxr <= dx_next;
      dyr <= dy_next;
      cxr <= cx_next;
      cyr <= cy_next;
    end
    a_dx   <= dxr[cnt[3:2]];
    a_dy   <= dyr[cnt[1:0]];
    a_addr <= {cxr[cnt[3:2]], cyr[cnt[1:0]]};
    b_p    <= 32'(a_dx) * 32'(a_dy);
    b_addr <= a_addr;
    c_p    <= 56'(b_p) * 56'(dl_r);
    c_addr <= b_addr;
    d_lo_x <= 64'(mag_x) * 64'(w[31:0]);
    d_lo_y <= 64'(mag_y) * 64'(w[31:0]);
    d_hi_x <= 64'(mag_x) * 64'(w[WW-1:32]);
    d_hi_y <= 64'(mag_y) * 64'(w[WW-1:32]);
    d_addr <= c_addr;
    e_cx   <= neg_x ? -$signed(res_x) : $signed(res_x);
    e_cy   <= neg_y ? -$signed(res_y) : $signed(res_y);
    e_addr <= d_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      cnt      <= '0;
      a_vld    <= 1'b0;
      b_vld    <= 1'b0;
      c_vld    <= 1'b0;
      d_vld    <= 1'b0;
      e_vld    <= 1'b0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else begin
      a_vld <= (state == ST_RUN);
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
      e_vld <= d_vld;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_xfer) begin
            unique case (op)
              OP_CLEAR: begin
                clr_addr <= '0;
                state <= ST_CLEAR;
              end
              OP_DEPOSIT: state <= ST_SETUP;
              OP_READ: state <= ST_READ;
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_SETUP: begin
          cnt <= '0;
          state <= ST_RUN;
        end
        ST_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == 4'd15) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!a_vld && !b_vld && !c_vld && !d_vld && !e_vld) state <= ST_IDLE;
        end
        ST_READ: state <= ST_LOAD;
        ST_LOAD: begin
          m_tdata  <= {rd_y, rd_x};
          m_tvalid <= 1'b1;
          state    <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/fsg_checker.sv
module fsg_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [1:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [95:0]  m_tdata
);
  import fsg_pkg::*;

  // clearing pass follows reset
  a_reset_busy: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready right after reset");

  a_deposit_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == OP_DEPOSIT |=> !s_tready)
    else $error("input ready right after deposit transfer");

  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == OP_READ |-> ##3 m_tvalid)
    else $error("read result missing");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind force_spreading_to_grid_core fsg_checker u_fsg_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
